>>> sv/fhra_pkg.sv
// ----------------------------------------------------------------------------
// fhra_pkg
// Shared types and codes for the free-range heap sector allocator.
// ----------------------------------------------------------------------------
package fhra_pkg;

  localparam int FIELD_W = 32;

  // request kinds
  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_FREE   = 2'd1;
  localparam logic [1:0] FN_FORMAT = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // first sector handed out after format, sector count after reset
  localparam logic [FIELD_W-1:0] FIRST_FREE    = 32'd2;
  localparam logic [FIELD_W-1:0] TOTAL_DEFAULT = 32'd1024;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] alloc_sector_out;
    logic [1:0]         status;
  } rsp_t;

endpackage

>>> sv/fhra_ram.sv
// ----------------------------------------------------------------------------
// fhra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/fhra_cmp.sv
// ----------------------------------------------------------------------------
// fhra_cmp
// Shared unsigned magnitude compare used by every heap decision.
// ----------------------------------------------------------------------------
module fhra_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt
);

  assign lt = (a < b);

endmodule

>>> sv/fhra_core.sv
// ----------------------------------------------------------------------------
// fhra_core
// Request sequencer: walks the range heap one level at a time through the
// heap RAM, using one shared compare unit for every ordering decision.
// ----------------------------------------------------------------------------
module fhra_core import fhra_pkg::*; #(
  parameter int HEAP_ENTRIES = 64,
  parameter int SECTOR_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [SECTOR_BITS-1:0]            total,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  req_t                              req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output rsp_t                              rsp,
  output logic                              ram_we,
  output logic [$clog2(HEAP_ENTRIES)-1:0]   ram_waddr,
  output logic [2*SECTOR_BITS-1:0]          ram_wdata,
  output logic                              ram_re,
  output logic [$clog2(HEAP_ENTRIES)-1:0]   ram_raddr,
  input  logic [2*SECTOR_BITS-1:0]          ram_rdata
);

  localparam int SB = SECTOR_BITS;
  localparam int AW = $clog2(HEAP_ENTRIES);
  localparam int CW = $clog2(HEAP_ENTRIES + 1);

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_ALLOC = 11'b00000000100,
    S_LAST  = 11'b00000001000,
    S_DN    = 11'b00000010000,
    S_DN_L  = 11'b00000100000,
    S_DN_R  = 11'b00001000000,
    S_DN_C  = 11'b00010000000,
    S_UPCHK = 11'b00100000000,
    S_UP    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [SB-1:0] cur_start, cur_start_next, cur_end, cur_end_next;
  logic [SB-1:0] sel_start, sel_start_next, sel_end, sel_end_next;
  logic [CW-1:0] sel_idx, sel_idx_next;
  rsp_t          rsp_q, rsp_next;

  logic [SB-1:0] rd_start, rd_end, req_sec, inc_rd, inc_sec;
  logic [CW:0]   lch, rch, cnt_ext, lch_m1, rch_m1;
  logic [CW-1:0] idx_m1, cnt_m1, parent, parent_m1;
  logic          has_l, has_r;
  logic [SB-1:0] cmp_a, cmp_b;
  logic          cmp_lt;

  assign rd_start  = ram_rdata[2*SB-1:SB];
  assign rd_end    = ram_rdata[SB-1:0];
  assign req_sec   = req.sector[SB-1:0];
  assign inc_rd    = rd_start + 1'b1;
  assign inc_sec   = req_sec + 1'b1;
  assign lch       = {idx, 1'b0};
  assign rch       = {idx, 1'b1};
  assign cnt_ext   = {1'b0, count};
  assign lch_m1    = lch - 1'b1;
  assign rch_m1    = rch - 1'b1;
  assign idx_m1    = idx - 1'b1;
  assign cnt_m1    = count - 1'b1;
  assign parent    = idx >> 1;
  assign parent_m1 = parent - 1'b1;
  assign has_l     = (lch <= cnt_ext);
  assign has_r     = (rch <= cnt_ext);

  fhra_cmp #(.W(SB)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  // operand select for the shared compare
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state)
      S_INIT, S_IDLE: begin
        cmp_a = FIRST_FREE[SB-1:0];
        cmp_b = total;
      end
      S_ALLOC: begin
        cmp_a = inc_rd;
        cmp_b = rd_end;
      end
      S_DN_L: begin
        cmp_a = rd_start;
        cmp_b = cur_start;
      end
      S_DN_R: begin
        cmp_a = sel_start;
        cmp_b = rd_start;
      end
      S_DN_C: begin
        cmp_a = sel_start;
        cmp_b = cur_start;
      end
      S_UP: begin
        cmp_a = cur_start;
        cmp_b = rd_start;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    cur_start_next = cur_start;
    cur_end_next   = cur_end;
    sel_start_next = sel_start;
    sel_end_next   = sel_end;
    sel_idx_next   = sel_idx;
    rsp_next       = rsp_q;
    ram_we         = 1'b0;
    ram_waddr      = idx_m1[AW-1:0];
    ram_wdata      = {cur_start, cur_end};
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state)
      S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = {FIRST_FREE[SB-1:0], total};
        count_next = cmp_lt ? CW'(1) : '0;
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (req_valid) begin
          rsp_next.alloc_sector_out = '0;
          rsp_next.status           = ST_OK;
          case (req.func)
            FN_ALLOC: begin
              if (count == '0) begin
                rsp_next.status = ST_EMPTY;
                state_next      = S_OUT;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_ALLOC;
              end
            end
            FN_FREE: begin
              if (req_sec == '0) begin
                rsp_next.status = ST_ZERO;
                state_next      = S_OUT;
              end else if (count == CW'(HEAP_ENTRIES)) begin
                rsp_next.status = ST_FULL;
                state_next      = S_OUT;
              end else begin
                count_next     = count + 1'b1;
                idx_next       = count + 1'b1;
                cur_start_next = req_sec;
                cur_end_next   = inc_sec;
                state_next     = S_UPCHK;
              end
            end
            FN_FORMAT: begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = {FIRST_FREE[SB-1:0], total};
              count_next = cmp_lt ? CW'(1) : '0;
              state_next = S_OUT;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end

      S_ALLOC: begin
        rsp_next.alloc_sector_out = FIELD_W'(rd_start);
        if (cmp_lt) begin
          // root range still has sectors left
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = {inc_rd, rd_end};
          state_next = S_OUT;
        end else if (count == CW'(1)) begin
          count_next = '0;
          state_next = S_OUT;
        end else begin
          // fetch last entry to refill the root
          ram_re     = 1'b1;
          ram_raddr  = cnt_m1[AW-1:0];
          count_next = cnt_m1;
          state_next = S_LAST;
        end
      end

      S_LAST: begin
        cur_start_next = rd_start;
        cur_end_next   = rd_end;
        idx_next       = CW'(1);
        state_next     = S_DN;
      end

      S_DN: begin
        if (!has_l) begin
          ram_we     = 1'b1;
          state_next = S_OUT;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = lch_m1[AW-1:0];
          state_next = S_DN_L;
        end
      end

      S_DN_L: begin
        sel_start_next = rd_start;
        sel_end_next   = rd_end;
        sel_idx_next   = lch[CW-1:0];
        if (has_r) begin
          ram_re     = 1'b1;
          ram_raddr  = rch_m1[AW-1:0];
          state_next = S_DN_R;
        end else if (cmp_lt) begin
          ram_we     = 1'b1;
          ram_wdata  = {rd_start, rd_end};
          idx_next   = lch[CW-1:0];
          state_next = S_DN;
        end else begin
          ram_we     = 1'b1;
          state_next = S_OUT;
        end
      end

      S_DN_R: begin
        // ties go to the right child
        if (!cmp_lt) begin
          sel_start_next = rd_start;
          sel_end_next   = rd_end;
          sel_idx_next   = rch[CW-1:0];
        end
        state_next = S_DN_C;
      end

      S_DN_C: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata  = {sel_start, sel_end};
          idx_next   = sel_idx;
          state_next = S_DN;
        end else begin
          state_next = S_OUT;
        end
      end

      S_UPCHK: begin
        if (idx == CW'(1)) begin
          ram_we     = 1'b1;
          state_next = S_OUT;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = parent_m1[AW-1:0];
          state_next = S_UP;
        end
      end

      S_UP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata  = {rd_start, rd_end};
          idx_next   = parent;
          state_next = S_UPCHK;
        end else begin
          state_next = S_OUT;
        end
      end

      S_OUT: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx       <= idx_next;
    cur_start <= cur_start_next;
    cur_end   <= cur_end_next;
    sel_start <= sel_start_next;
    sel_end   <= sel_end_next;
    sel_idx   <= sel_idx_next;
    rsp_q     <= rsp_next;
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp       = rsp_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_ENTRIES))
    else $error("heap count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("heap RAM read and write to same slot");

  a_idx_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN || state == S_UPCHK) |-> (idx != '0 && idx <= count))
    else $error("sift index outside heap");

  a_err_no_sector: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.alloc_sector_out == '0))
    else $error("failed request returned a sector");

endmodule

>>> sv/free_range_heap_allocator.sv
// ----------------------------------------------------------------------------
// free_range_heap_allocator
// Sector allocator keeping free ranges in a binary min-heap ordered by start.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): one request per transfer, func is
//   allocate, free or format. rsp channel (rsp_valid/rsp_stall/rsp): exactly
//   one response per request, in order. cfg channel (cfg_valid/cfg_ready/
//   cfg_data) writes total_sectors; it is always ready and is meant to be
//   written only while no request is in flight.
// Timing: format and rejected requests go straight to the response; an
//   allocate reads the root and, if that empties it and other ranges remain,
//   reads the last entry and sifts it down; a free sifts the new range up.
//   Levels are at most log2(HEAP_ENTRIES); each level costs one or two reads
//   of the heap RAM plus compares.
// One request at a time: req_stall stays high from transfer until the
//   response has been taken; the next request can transfer in the cycle
//   after the response transfer. While rsp_stall is high the response holds.
// Reset: total_sectors returns to 1024 and the heap is rebuilt to one range
//   in the S_INIT state, during which req_stall is high.
// ----------------------------------------------------------------------------
module free_range_heap_allocator import fhra_pkg::*; #(
  parameter int HEAP_ENTRIES = 64,
  parameter int SECTOR_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] cfg_data
);

  localparam int AW = $clog2(HEAP_ENTRIES);
  localparam int EW = 2 * SECTOR_BITS;

  logic [FIELD_W-1:0] total_sectors;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_sectors <= TOTAL_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      total_sectors <= cfg_data;
    end
  end

  fhra_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_ENTRIES)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fhra_core #(
    .HEAP_ENTRIES (HEAP_ENTRIES),
    .SECTOR_BITS  (SECTOR_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .total     (total_sectors[SECTOR_BITS-1:0]),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

>>> bench/tb_free_range_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_free_range_heap_allocator
// Self-checking bench for the free-range heap sector allocator. A clocked
// driver feeds allocate/free/format requests from a queue, and a clocked
// monitor checks every response against an in-bench heap model. Disk size is
// changed between phases, and both sides idle at random, including one long
// response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_free_range_heap_allocator import fhra_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HEAP_N = 64;
  localparam logic [1:0] FN_NOP = 2'd3;  // unused request code, no-op

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_t               req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data = '0;

  free_range_heap_allocator #(
    .HEAP_ENTRIES(HEAP_N),
    .SECTOR_BITS (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // heap model: free ranges [lo, hi), min-heap on lo, slots 1..heap_n
  // ---------------------------------------------------------------------------
  logic [31:0] rng_lo [1:HEAP_N];
  logic [31:0] rng_hi [1:HEAP_N];
  int          heap_n;
  logic [31:0] disk_total;
  logic [31:0] loaned[$];  // sectors handed out, recycled by the free stimulus

  int n_handed, n_empty, n_full, n_zero, n_format, n_sizes;

  function automatic void heap_swap(int a, int b);
    logic [31:0] t_lo, t_hi;
    t_lo = rng_lo[a];
    t_hi = rng_hi[a];
    rng_lo[a] = rng_lo[b];
    rng_hi[a] = rng_hi[b];
    rng_lo[b] = t_lo;
    rng_hi[b] = t_hi;
  endfunction

  function automatic void heap_rebuild();
    for (int i = 1; i <= HEAP_N; i++) begin
      rng_lo[i] = '0;
      rng_hi[i] = '0;
    end
    if (disk_total > FIRST_FREE) begin
      rng_lo[1] = FIRST_FREE;
      rng_hi[1] = disk_total;
      heap_n = 1;
    end else begin
      heap_n = 0;
    end
  endfunction

  function automatic void sink_root();
    int i, l, r, c;
    i = 1;
    forever begin
      l = 2 * i;
      r = l + 1;
      if (l > heap_n) break;
      c = l;
      // ties go right
      if (r <= heap_n && !(rng_lo[l] < rng_lo[r])) c = r;
      if (rng_lo[c] < rng_lo[i]) begin
        heap_swap(c, i);
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void float_up(int i);
    while (i > 1 && rng_lo[i / 2] > rng_lo[i]) begin
      heap_swap(i, i / 2);
      i = i / 2;
    end
  endfunction

  // applies one request to the model and returns the response it owes
  function automatic rsp_t heap_service(req_t r);
    rsp_t        o;
    logic [31:0] nxt;
    o = '0;
    o.status = ST_OK;
    case (r.func)
      FN_ALLOC: begin
        if (heap_n == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else begin
          o.alloc_sector_out = rng_lo[1];
          n_handed++;
          loaned.push_back(rng_lo[1]);
          if (loaned.size() > 200) void'(loaned.pop_front());
          nxt = rng_lo[1] + 32'd1;  // wraps at the top sector
          rng_lo[1] = nxt;
          if (nxt >= rng_hi[1]) begin
            rng_lo[1] = rng_lo[heap_n];
            rng_hi[1] = rng_hi[heap_n];
            rng_lo[heap_n] = '0;
            rng_hi[heap_n] = '0;
            heap_n--;
            sink_root();
          end
        end
      end
      FN_FREE: begin
        if (r.sector == '0) begin
          o.status = ST_ZERO;
          n_zero++;
        end else if (heap_n >= HEAP_N) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          heap_n++;
          rng_lo[heap_n] = r.sector;
          rng_hi[heap_n] = r.sector + 32'd1;
          float_up(heap_n);
        end
      end
      FN_FORMAT: begin
        heap_rebuild();
        n_format++;
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  int errors = 0;

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= 50) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  req_t pending_reqs[$];
  rsp_t owed_rsps[$];
  logic req_took = 1'b0;
  bit   drv_idle = 1'b1;
  bit   rcv_idle = 1'b1;
  int   send_gap = 0;

  function automatic int pick_send_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!drv_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        send_gap = pick_send_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response receiver: random stalls plus a commanded long hold-off
  // ---------------------------------------------------------------------------
  int hold_request = 0;
  int hold_left = 0;
  int stall_run = 0;

  always @(negedge clk) begin
    int roll;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (!rcv_idle) begin
        rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
        rsp_stall <= 1'b1;
        stall_run--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          rsp_stall <= 1'b0;
        end else begin
          rsp_stall <= 1'b1;
          stall_run = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check the response transfer, then model the request transfer
  // ---------------------------------------------------------------------------
  int reqs_taken = 0;
  int rsps_seen = 0;

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsps.size() == 0) begin
          flag_mismatch($sformatf("response %0d with none outstanding", rsps_seen));
        end else begin
          want = owed_rsps.pop_front();
          if (rsp.alloc_sector_out !== want.alloc_sector_out)
            flag_mismatch($sformatf("rsp %0d sector %h, model %h", rsps_seen,
                                    rsp.alloc_sector_out, want.alloc_sector_out));
          if (rsp.status !== want.status)
            flag_mismatch($sformatf("rsp %0d status %0d, model %0d", rsps_seen,
                                    rsp.status, want.status));
        end
        rsps_seen++;
      end
      req_took <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        owed_rsps.push_back(heap_service(req));
        reqs_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(logic [1:0] fn, logic [31:0] sec);
    req_t r;
    r.func = fn;
    r.sector = sec;
    pending_reqs.push_back(r);
  endtask

  // wait until every queued request is through and every response is back
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    disk_total = v;
    n_sizes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly alloc and free of sectors handed out earlier, plus noise
  task automatic gen_mix(int count, int fmt_pct);
    req_t r;
    int   roll;
    int   pick;
    for (int i = 0; i < count; i++) begin
      while (pending_reqs.size() > 4) @(posedge clk);
      roll = $urandom_range(0, 99);
      r.sector = $urandom;
      r.func = FN_FREE;
      if (roll < 40) begin
        r.func = FN_ALLOC;
      end else if (roll < 70) begin
        if (loaned.size() != 0) begin
          pick = $urandom_range(0, loaned.size() - 1);
          r.sector = loaned[pick];
          loaned.delete(pick);
        end else begin
          r.sector = $urandom_range(1, 3000);
        end
      end else if (roll < 80) begin
        // full-width random sector, already set
      end else if (roll < 83) begin
        r.sector = '0;
      end else if (roll < 86) begin
        r.sector = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end else if (roll < 98 - fmt_pct) begin
        r.sector = $urandom_range(1, 3000);
      end else if (roll < 98) begin
        r.func = FN_FORMAT;
      end else if (roll == 98) begin
        r.func = FN_NOP;
      end else begin
        r.func = FN_ALLOC;
      end
      pending_reqs.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    disk_total = TOTAL_DEFAULT;
    heap_rebuild();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: default disk [2,1024)
    queue_req(FN_ALLOC, 32'hFFFF_FFFF);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_FREE, 32'h0);
    queue_req(FN_FREE, 32'd2);
    queue_req(FN_FREE, 32'd3);
    queue_req(FN_FREE, 32'd3);               // double free, equal starts
    queue_req(FN_ALLOC, 32'h5555_5555);      // root empties, tie in sift-down
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_NOP, 32'hFFFF_FFFF);
    queue_req(FN_FREE, 32'hFFFF_FFFF);
    queue_req(FN_FORMAT, 32'hAAAA_AAAA);
    drain();

    // smallest disk: one sector, then top-sector wrap
    write_total(32'd3);
    queue_req(FN_FORMAT, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_FREE, 32'hFFFF_FFFF);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_FREE, 32'd1);
    queue_req(FN_ALLOC, 32'h8000_0000);
    drain();

    // disk too small for any range
    write_total(32'd2);
    queue_req(FN_FORMAT, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    drain();

    // largest disk
    write_total(32'hFFFF_FFFF);
    queue_req(FN_FORMAT, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    gen_mix(300, 2);

    // long response hold-off while a burst of frees fills the heap
    drain();
    @(posedge clk);
    hold_request = 300;
    for (int i = 0; i < 70; i++) queue_req(FN_FREE, $urandom_range(1, 32'hFFFF_FFFF));
    drain();

    write_total(32'd3);
    queue_req(FN_FORMAT, 32'h0);
    gen_mix(150, 8);
    drain();

    // small disk, back-to-back traffic
    write_total($urandom_range(3, 80));
    drv_idle = 1'b0;
    rcv_idle = 1'b0;
    queue_req(FN_FORMAT, 32'h0);
    gen_mix(300, 3);
    drain();
    drv_idle = 1'b1;
    rcv_idle = 1'b1;

    write_total(32'd0);
    queue_req(FN_FORMAT, 32'h0);
    queue_req(FN_ALLOC, 32'h0);
    queue_req(FN_FREE, 32'd5);
    queue_req(FN_ALLOC, 32'h0);
    drain();

    write_total($urandom);
    queue_req(FN_FORMAT, 32'h0);
    gen_mix(150, 3);
    drain();

    repeat (40) @(posedge clk);
    if (owed_rsps.size() != 0)
      flag_mismatch($sformatf("%0d responses never arrived", owed_rsps.size()));

    $display("Run covered %0d requests over %0d disk sizes, %0d formats.",
             reqs_taken, n_sizes + 1, n_format);
    $display("Handed out %0d sectors; %0d empty-heap, %0d full-heap, %0d zero-sector.",
             n_handed, n_empty, n_full, n_zero);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Timeout: %0d requests taken, %0d responses seen", reqs_taken, rsps_seen);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
